FILE: design/tcc_pkg.sv
// tcc_pkg: shared constants and the arctangent table for the tilt-compensated compass
// used by tcc_vec and tilt_compensated_compass; no dependencies
package tcc_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int FIELD_W          = 16;
   localparam int TABLE_LEN        = 24;
   localparam int ANG_W            = 32;
   localparam int OUT_W            = 16;
   localparam int PITCH_W          = 15;
   localparam int HEAD_W           = 16;
   localparam int GAIN_W           = 18;
   localparam int FRAC_BITS        = 16;

   localparam logic signed [ANG_W-1:0] ANG_90     = 32'sd589824000;
   localparam logic signed [ANG_W-1:0] ROUND_HALF = 32'sd32768;
   localparam int GAIN_Q16   = 107922;

   localparam logic signed [OUT_W-1:0] ROLL_LIM  = 16'sd18000;
   localparam logic signed [OUT_W-1:0] PITCH_LIM = 16'sd9000;
   localparam logic signed [OUT_W:0]   FULL_TURN = 17'sd36000;

   // atan(2^-i) in hundredths of a degree, times 2^16
   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] idx);
      logic signed [ANG_W-1:0] r;
      unique case (idx)
         5'd0:    r = 32'sd294912000;
         5'd1:    r = 32'sd174096719;
         5'd2:    r = 32'sd91987925;
         5'd3:    r = 32'sd46694507;
         5'd4:    r = 32'sd23437865;
         5'd5:    r = 32'sd11730358;
         5'd6:    r = 32'sd5866610;
         5'd7:    r = 32'sd2933484;
         5'd8:    r = 32'sd1466764;
         5'd9:    r = 32'sd733385;
         5'd10:   r = 32'sd366693;
         5'd11:   r = 32'sd183346;
         5'd12:   r = 32'sd91673;
         5'd13:   r = 32'sd45837;
         5'd14:   r = 32'sd22918;
         5'd15:   r = 32'sd11459;
         5'd16:   r = 32'sd5730;
         5'd17:   r = 32'sd2865;
         5'd18:   r = 32'sd1432;
         5'd19:   r = 32'sd716;
         5'd20:   r = 32'sd358;
         5'd21:   r = 32'sd179;
         5'd22:   r = 32'sd90;
         5'd23:   r = 32'sd45;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/tilt_compensated_compass.sv
// tilt-compensated compass: one request per cycle unless a finished result is stalled;
// the rate is set by the three chained cordic pipelines,
// each micro-rotation a register stage of its own
// the whole pipeline holds while a finished result is stalled
// synchronous reset clears the valid bits only; no other state
// depends on tcc_pkg and tcc_vec
module tilt_compensated_compass #(
   parameter int CORDIC_STEPS = tcc_pkg::CORDIC_STEPS_DEF,
   parameter int SAMPLE_BITS  = tcc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [tcc_pkg::FIELD_W-1:0]  req_accel_x,
   input  logic signed [tcc_pkg::FIELD_W-1:0]  req_accel_y,
   input  logic signed [tcc_pkg::FIELD_W-1:0]  req_accel_z,
   input  logic signed [tcc_pkg::FIELD_W-1:0]  req_field_x,
   input  logic signed [tcc_pkg::FIELD_W-1:0]  req_field_y,
   input  logic signed [tcc_pkg::FIELD_W-1:0]  req_field_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tcc_pkg::OUT_W-1:0]    rsp_roll_cdeg,
   output logic signed [tcc_pkg::PITCH_W-1:0]  rsp_pitch_cdeg,
   output logic [tcc_pkg::HEAD_W-1:0]          rsp_heading_cdeg,
   output logic                                rsp_gravity_fault
);

   // guard bits lift each sample, plus headroom for cordic and gain growth
   localparam int GUARD  = 32 - SAMPLE_BITS;
   localparam int DW     = tcc_pkg::FIELD_W + GUARD + 5;
   localparam int NSTEPS = (CORDIC_STEPS > tcc_pkg::TABLE_LEN) ?
                           tcc_pkg::TABLE_LEN : CORDIC_STEPS;
   localparam int PW     = DW + tcc_pkg::GAIN_W;
   localparam int OW     = tcc_pkg::OUT_W;
   localparam int RSB    = 1 + 2 * DW;
   localparam int PSB    = 1 + OW + DW;
   localparam int HSB    = 1 + 2 * OW;

   localparam logic signed [PW-1:0] GAIN_K = PW'(tcc_pkg::GAIN_Q16);
   localparam logic signed [PW-1:0] G_RND  = PW'(32768);

   // v*K with round to nearest, floor shift
   function automatic logic signed [DW-1:0] mul_gain(input logic signed [DW-1:0] v);
      logic signed [PW-1:0] p;
      p = PW'(v) * GAIN_K + G_RND;
      return p[tcc_pkg::FRAC_BITS +: DW];
   endfunction

   // whole pipeline advances unless the result register is held
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // input stage: scale samples and pre-form the gain products
   logic                 s0_valid_ff;
   logic                 s0_fault_ff;
   logic signed [DW-1:0] s0_gy_ff, s0_gz_ff, s0_my_ff, s0_mz_ff;
   logic signed [DW-1:0] s0_kgx_ff, s0_kmx_ff, s0_kmy_ff, s0_kmz_ff;
   logic signed [DW-1:0] gx_in, gy_in, gz_in, mx_in, my_in, mz_in;

   assign gx_in = DW'(req_accel_x) <<< GUARD;
   assign gy_in = DW'(req_accel_y) <<< GUARD;
   assign gz_in = DW'(req_accel_z) <<< GUARD;
   assign mx_in = DW'(req_field_x) <<< GUARD;
   assign my_in = DW'(req_field_y) <<< GUARD;
   assign mz_in = DW'(req_field_z) <<< GUARD;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_fault_ff <= (req_accel_x == '0) && (req_accel_y == '0) && (req_accel_z == '0);
         s0_gy_ff    <= gy_in;
         s0_gz_ff    <= gz_in;
         s0_my_ff    <= my_in;
         s0_mz_ff    <= mz_in;
         s0_kgx_ff   <= mul_gain(-gx_in);
         s0_kmx_ff   <= mul_gain(mx_in);
         s0_kmy_ff   <= mul_gain(my_in);
         s0_kmz_ff   <= mul_gain(mz_in);
      end
   end

   // roll: vector (az, ay), companion (mz, my)
   logic                 r_valid;
   logic signed [DW-1:0] r_x, r_u, r_v;
   logic signed [OW-1:0] r_ang;
   logic [RSB-1:0]       r_sb;

   tcc_vec #(.DW(DW), .STEPS(NSTEPS), .SBW(RSB)) u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_x      (s0_gz_ff),
      .in_y      (s0_gy_ff),
      .in_u      (s0_mz_ff),
      .in_v      (s0_my_ff),
      .in_ku     (s0_kmz_ff),
      .in_kv     (s0_kmy_ff),
      .in_sb     ({s0_fault_ff, s0_kgx_ff, s0_kmx_ff}),
      .out_valid (r_valid),
      .out_x     (r_x),
      .out_u     (r_u),
      .out_v     (r_v),
      .out_ang   (r_ang),
      .out_sb    (r_sb)
   );

   // gain stage between roll and pitch; also forms the heading y operand
   logic                 s1_valid_ff, s1_fault_ff;
   logic signed [OW-1:0] s1_roll_ff;
   logic signed [DW-1:0] s1_px_ff, s1_py_ff, s1_qu_ff, s1_qv_ff;
   logic signed [DW-1:0] s1_kqu_ff, s1_kqv_ff, s1_hy_ff;
   logic signed [DW-1:0] r_kgx, r_kmx;
   logic                 r_fault;

   assign {r_fault, r_kgx, r_kmx} = r_sb;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_fault_ff <= r_fault;
         s1_roll_ff  <= r_ang;
         s1_px_ff    <= r_x;
         s1_py_ff    <= r_kgx;
         s1_qu_ff    <= r_kmx;
         s1_qv_ff    <= r_u;
         s1_kqu_ff   <= mul_gain(r_kmx);
         s1_kqv_ff   <= mul_gain(r_u);
         s1_hy_ff    <= -mul_gain(r_v);
      end
   end

   // pitch: vector (K*r, -K*ax), companion (K*mx, de-rolled z field)
   logic                 p_valid;
   logic signed [DW-1:0] p_u;
   logic signed [OW-1:0] p_ang;
   logic [PSB-1:0]       p_sb;
   logic                 p_fault;
   logic signed [OW-1:0] p_roll;
   logic signed [DW-1:0] p_hy;

   tcc_vec #(.DW(DW), .STEPS(NSTEPS), .SBW(PSB)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_x      (s1_px_ff),
      .in_y      (s1_py_ff),
      .in_u      (s1_qu_ff),
      .in_v      (s1_qv_ff),
      .in_ku     (s1_kqu_ff),
      .in_kv     (s1_kqv_ff),
      .in_sb     ({s1_fault_ff, s1_roll_ff, s1_hy_ff}),
      .out_valid (p_valid),
      .out_x     (),
      .out_u     (p_u),
      .out_v     (),
      .out_ang   (p_ang),
      .out_sb    (p_sb)
   );

   assign {p_fault, p_roll, p_hy} = p_sb;

   // heading: vector (Bfx, -K*Bfy), no companion
   logic                 h_valid;
   logic signed [OW-1:0] h_ang;
   logic [HSB-1:0]       h_sb;
   logic                 h_fault;
   logic signed [OW-1:0] h_roll, h_pitch;

   tcc_vec #(.DW(DW), .STEPS(NSTEPS), .SBW(HSB)) u_head (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_x      (p_u),
      .in_y      (p_hy),
      .in_u      ('0),
      .in_v      ('0),
      .in_ku     ('0),
      .in_kv     ('0),
      .in_sb     ({p_fault, p_roll, p_ang}),
      .out_valid (h_valid),
      .out_x     (),
      .out_u     (),
      .out_v     (),
      .out_ang   (h_ang),
      .out_sb    (h_sb)
   );

   assign {h_fault, h_roll, h_pitch} = h_sb;

   // output stage: clamp roll and pitch, wrap heading, zero on fault
   logic signed [OW-1:0] roll_in, pitch_in;
   logic signed [OW:0]   head_in;

   always_comb begin
      roll_in = h_roll;
      if (h_roll > tcc_pkg::ROLL_LIM) begin
         roll_in = tcc_pkg::ROLL_LIM;
      end else if (h_roll < -tcc_pkg::ROLL_LIM) begin
         roll_in = -tcc_pkg::ROLL_LIM;
      end
      pitch_in = h_pitch;
      if (h_pitch > tcc_pkg::PITCH_LIM) begin
         pitch_in = tcc_pkg::PITCH_LIM;
      end else if (h_pitch < -tcc_pkg::PITCH_LIM) begin
         pitch_in = -tcc_pkg::PITCH_LIM;
      end
      head_in = (OW+1)'(h_ang);
      if (head_in < 0) begin
         head_in = head_in + tcc_pkg::FULL_TURN;
      end else if (head_in >= tcc_pkg::FULL_TURN) begin
         head_in = head_in - tcc_pkg::FULL_TURN;
      end
      if (h_fault) begin
         roll_in  = '0;
         pitch_in = '0;
         head_in  = '0;
      end
   end

   logic                               out_valid_ff;
   logic signed [OW-1:0]               roll_ff;
   logic signed [tcc_pkg::PITCH_W-1:0] pitch_ff;
   logic [tcc_pkg::HEAD_W-1:0]         head_ff;
   logic                               fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= h_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in[tcc_pkg::PITCH_W-1:0];
         head_ff  <= head_in[tcc_pkg::HEAD_W-1:0];
         fault_ff <= h_fault;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_roll_cdeg     = roll_ff;
   assign rsp_pitch_cdeg    = pitch_ff;
   assign rsp_heading_cdeg  = head_ff;
   assign rsp_gravity_fault = fault_ff;

endmodule

FILE: design/tcc_vec.sv
// tcc_vec: pipelined vectoring cordic with a companion vector and a sideband
// depends on tcc_pkg
module tcc_vec #(
   parameter int DW    = 37,
   parameter int STEPS = 16,
   parameter int SBW   = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [DW-1:0]    in_x,
   input  logic signed [DW-1:0]    in_y,
   input  logic signed [DW-1:0]    in_u,
   input  logic signed [DW-1:0]    in_v,
   input  logic signed [DW-1:0]    in_ku,
   input  logic signed [DW-1:0]    in_kv,
   input  logic [SBW-1:0]          in_sb,
   output logic                    out_valid,
   output logic signed [DW-1:0]    out_x,
   output logic signed [DW-1:0]    out_u,
   output logic signed [DW-1:0]    out_v,
   output logic signed [tcc_pkg::OUT_W-1:0] out_ang,
   output logic [SBW-1:0]          out_sb
);

   logic                           valid_ff [0:STEPS];
   logic                           zero_ff  [0:STEPS];
   logic signed [DW-1:0]           x_ff     [0:STEPS];
   logic signed [DW-1:0]           y_ff     [0:STEPS];
   logic signed [DW-1:0]           u_ff     [0:STEPS];
   logic signed [DW-1:0]           v_ff     [0:STEPS];
   logic signed [DW-1:0]           ku_ff    [0:STEPS];
   logic signed [DW-1:0]           kv_ff    [0:STEPS];
   logic signed [tcc_pkg::ANG_W-1:0] acc_ff [0:STEPS];
   logic [SBW-1:0]                 sb_ff    [0:STEPS];

   logic signed [DW-1:0]           x_in, y_in, u_in, v_in;
   logic signed [tcc_pkg::ANG_W-1:0] acc_in;
   logic signed [tcc_pkg::ANG_W-1:0] rnd;

   logic                           out_valid_ff;
   logic signed [DW-1:0]           out_x_ff, out_u_ff, out_v_ff;
   logic signed [tcc_pkg::OUT_W-1:0] out_ang_ff;
   logic [SBW-1:0]                 out_sb_ff;

   // quarter turn into the right half plane
   always_comb begin
      x_in   = in_x;
      y_in   = in_y;
      u_in   = in_u;
      v_in   = in_v;
      acc_in = '0;
      if (in_x[DW-1]) begin
         if (!in_y[DW-1]) begin
            x_in   = in_y;
            y_in   = -in_x;
            u_in   = in_v;
            v_in   = -in_u;
            acc_in = tcc_pkg::ANG_90;
         end else begin
            x_in   = -in_y;
            y_in   = in_x;
            u_in   = -in_v;
            v_in   = in_u;
            acc_in = -tcc_pkg::ANG_90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         u_ff[0]    <= u_in;
         v_ff[0]    <= v_in;
         ku_ff[0]   <= in_ku;
         kv_ff[0]   <= in_kv;
         acc_ff[0]  <= acc_in;
         sb_ff[0]   <= in_sb;
      end
   end

   // one micro-rotation per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[k+1] <= zero_ff[k];
            ku_ff[k+1]   <= ku_ff[k];
            kv_ff[k+1]   <= kv_ff[k];
            sb_ff[k+1]   <= sb_ff[k];
            if (!y_ff[k][DW-1]) begin
               x_ff[k+1]   <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1]   <= y_ff[k] - (x_ff[k] >>> k);
               u_ff[k+1]   <= u_ff[k] + (v_ff[k] >>> k);
               v_ff[k+1]   <= v_ff[k] - (u_ff[k] >>> k);
               acc_ff[k+1] <= acc_ff[k] + tcc_pkg::atan_q16(5'(k));
            end else begin
               x_ff[k+1]   <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1]   <= y_ff[k] + (x_ff[k] >>> k);
               u_ff[k+1]   <= u_ff[k] - (v_ff[k] >>> k);
               v_ff[k+1]   <= v_ff[k] + (u_ff[k] >>> k);
               acc_ff[k+1] <= acc_ff[k] - tcc_pkg::atan_q16(5'(k));
            end
         end
      end
   end

   assign rnd = acc_ff[STEPS] + tcc_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[STEPS];
      end
   end

   // zero vector: angle 0, companion only scaled by the gain
   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff   <= x_ff[STEPS];
         out_u_ff   <= zero_ff[STEPS] ? ku_ff[STEPS] : u_ff[STEPS];
         out_v_ff   <= zero_ff[STEPS] ? kv_ff[STEPS] : v_ff[STEPS];
         out_ang_ff <= zero_ff[STEPS] ? '0 :
                       rnd[tcc_pkg::FRAC_BITS +: tcc_pkg::OUT_W];
         out_sb_ff  <= sb_ff[STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_u     = out_u_ff;
   assign out_v     = out_v_ff;
   assign out_ang   = out_ang_ff;
   assign out_sb    = out_sb_ff;

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench for tilt_compensated_compass
// holds a bit-exact cordic predictor and a scoreboard class; depends on tcc_pkg and the rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS   = 16;
   localparam int SBITS   = 16;
   localparam int LAT     = 3 * STEPS + 9;
   localparam int N_RAND  = 1550;
   localparam int WD_LIM  = 20000;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic [15:0]        heading;
      logic               fault;
   } angles_type;

   // ---------------------------------------------------------------- predictor
   function automatic longint sra(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint gain(longint v);
      return sra(v * tcc_pkg::GAIN_Q16 + 32768, 16);
   endfunction

   function automatic longint atan_tab(int i);
      longint t [24] = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                         5866610, 2933484, 1466764, 733385, 366693, 183346,
                         91673, 45837, 22918, 11459, 5730, 2865,
                         1432, 716, 358, 179, 90, 45};
      return t[i];
   endfunction

   // vectoring cordic on (x, y), companion (u, v) follows the same turns
   function automatic longint rotate_to_axis(inout longint x, inout longint y,
                                             inout longint u, inout longint v);
      longint acc, t, dx, dy, du, dv;
      acc = 0;
      if (x == 0 && y == 0) begin
         u = gain(u);
         v = gain(v);
         return 0;
      end
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t;
            t = u; u = v; v = -t;
            acc = 64'sd589824000;
         end else begin
            t = x; x = -y; y = t;
            t = u; u = -v; v = t;
            acc = -64'sd589824000;
         end
      end
      for (int i = 0; i < STEPS && i < tcc_pkg::TABLE_LEN; i++) begin
         dx = sra(y, i); dy = sra(x, i); du = sra(v, i); dv = sra(u, i);
         if (y >= 0) begin
            x += dx; y -= dy; u += du; v -= dv; acc += longint'(atan_tab(i));
         end else begin
            x -= dx; y += dy; u -= du; v += dv; acc -= longint'(atan_tab(i));
         end
      end
      return sra(acc + 32768, 16);
   endfunction

   function automatic angles_type compass_angles(logic signed [15:0] ax, ay, az, fx, fy, fz);
      longint sc, gx, gy, gz, mx, my, mz, roll, pitch, head;
      longint rx, ry, cu, cv, px, py, qu, qv, hx, hy, du, dv;
      angles_type r;
      sc = longint'(1) << (32 - SBITS);
      gx = ax * sc; gy = ay * sc; gz = az * sc;
      mx = fx * sc; my = fy * sc; mz = fz * sc;
      roll = 0; pitch = 0; head = 0;
      r.fault = (gx == 0 && gy == 0 && gz == 0);
      if (!r.fault) begin
         rx = gz; ry = gy; cu = mz; cv = my;
         roll = rotate_to_axis(rx, ry, cu, cv);
         px = rx; py = gain(-gx); qu = gain(mx); qv = cu;
         pitch = rotate_to_axis(px, py, qu, qv);
         hx = qu; hy = -gain(cv); du = 0; dv = 0;
         head = rotate_to_axis(hx, hy, du, dv);
         if (roll > 18000) roll = 18000;
         if (roll < -18000) roll = -18000;
         if (pitch > 9000) pitch = 9000;
         if (pitch < -9000) pitch = -9000;
         if (head < 0) head += 36000;
         if (head >= 36000) head -= 36000;
      end
      r.roll = roll[15:0];
      r.pitch = pitch[14:0];
      r.heading = head[15:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- scoreboard
   class angle_board;
      angles_type pending[$];
      int mismatches = 0;
      int checked = 0;

      function void note_request(logic signed [15:0] ax, ay, az, fx, fy, fz);
         pending.push_back(compass_angles(ax, ay, az, fx, fy, fz));
      endfunction

      function void check_result(angles_type got);
         angles_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch #%0d: expected roll %0d pitch %0d head %0d fault %0b,",
                         " got roll %0d pitch %0d head %0d fault %0b"},
                        checked, want.roll, want.pitch, want.heading, want.fault,
                        got.roll, got.pitch, got.heading, got.fault);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------- dut
   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 1;
   logic signed [15:0] req_accel_x = 0, req_accel_y = 0, req_accel_z = 0;
   logic signed [15:0] req_field_x = 0, req_field_y = 0, req_field_z = 0;
   logic signed [15:0] rsp_roll_cdeg;
   logic signed [14:0] rsp_pitch_cdeg;
   logic [15:0]        rsp_heading_cdeg;
   logic               rsp_gravity_fault;

   tilt_compensated_compass dut (.*);

   always #6 clock = ~clock;

   angle_board board = new();
   int  idle_cycles = 0;
   bit  stim_done = 0;
   bit  hold_rsp = 0;      // long receiver hold-off asked by the sender process
   bit  hold_active = 0;
   int  sent = 0;

   // short gaps usually, a long one now and then
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // one request: offer at the falling edge, hold until accepted
   // valid stays up into the next request when there is no gap
   task automatic send_request(logic signed [15:0] ax, ay, az, fx, fy, fz);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_accel_x <= ax; req_accel_y <= ay; req_accel_z <= az;
      req_field_x <= fx; req_field_y <= fy; req_field_z <= fz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(ax, ay, az, fx, fy, fz);
      sent++;
      @(negedge clock);
   endtask

   // random sample: mostly realistic gravity/field magnitudes, some full-range noise
   function automatic logic signed [15:0] rand_sample(int mode);
      case (mode)
         0: return 16'($urandom());
         1: return 16'($signed($urandom_range(0, 8000)) - 4000);
         2: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      endcase
   endfunction

   // sender
   initial begin
      int mode;
      logic signed [15:0] s [6];
      logic signed [15:0] ext [4];
      ext = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
      repeat (6) @(negedge clock);
      reset <= 0;
      // directed: zero gravity, zero field, extremes, axis-aligned, quadrants
      send_request(0, 0, 0, 100, 200, 300);
      send_request(0, 0, 0, 0, 0, 0);
      send_request(100, 0, 0, 0, 0, 0);
      send_request(-100, 0, 0, 500, -500, 0);
      send_request(0, 0, 16384, 0, 0, 0);
      send_request(0, 0, 16384, 1000, 0, 0);
      send_request(0, 0, 16384, -1000, 0, 0);
      send_request(0, 0, 16384, 0, 1000, 0);
      send_request(0, 0, 16384, 0, -1000, 0);
      send_request(0, 0, -16384, 1000, 1000, 1000);
      send_request(0, 16384, 0, 300, -200, 100);
      send_request(0, -16384, 0, 300, -200, 100);
      send_request(0, 1, -16384, 300, 200, -100);
      send_request(0, -1, -16384, 300, 200, -100);
      send_request(16384, 0, 0, 300, 200, 100);
      send_request(-16384, 0, 0, 300, 200, 100);
      foreach (ext[i]) send_request(ext[i], ext[(i+1)%4], ext[(i+2)%4],
                                    ext[(i+3)%4], ext[i], ext[(i+1)%4]);
      send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_request(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      // random part, with a long receiver hold-off and a drain pause inside
      for (int n = 0; n < N_RAND; n++) begin
         if (n == 400) hold_rsp = 1;
         if (n == 800) begin
            // pause until everything outstanding has come back
            req_valid <= 0;
            @(negedge clock);
            while (board.pending.size() != 0) @(negedge clock);
         end
         mode = $urandom_range(0, 9);
         for (int k = 0; k < 6; k++)
            s[k] = rand_sample(mode < 3 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3);
         if ($urandom_range(0, 49) == 0) begin
            s[0] = 0; s[1] = 0; s[2] = 0;
         end
         send_request(s[0], s[1], s[2], s[3], s[4], s[5]);
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // receiver: random stall, or a long counted hold-off when asked
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (hold_rsp && !hold_active) begin
            hold_active = 1;
            rsp_stall <= 1;
            repeat (300) @(negedge clock);
         end else begin
            gap = pick_gap();
            rsp_stall <= (gap != 0);
            repeat (gap == 0 ? $urandom_range(1, 20) : gap) @(negedge clock);
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result('{rsp_roll_cdeg, rsp_pitch_cdeg,
                                 rsp_heading_cdeg, rsp_gravity_fault});
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0 && idle_cycles < WD_LIM) @(posedge clock);
      if (board.pending.size() != 0) begin
         $display("watchdog expired with %0d results outstanding", board.pending.size());
         $display("** tilt_compensated_compass: FAILED **");
         $finish;
      end
      repeat (LAT + 20) @(posedge clock);
      $display("sent %0d requests, checked %0d results incl. zero-gravity, extremes and stalls",
               sent, board.checked);
      $display("%0d mismatches", board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("** tilt_compensated_compass: PASSED **");
      else
         $display("** tilt_compensated_compass: FAILED **");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WD_LIM);
      $display("watchdog expired: no traffic for %0d cycles", WD_LIM);
      $display("** tilt_compensated_compass: FAILED **");
      $finish;
   end
endmodule
